// File: src/eight_queens_nearest_placement_defines.svh
// Assertion macros for the eight queens nearest placement block.
`ifndef EIGHT_QUEENS_NEAREST_PLACEMENT_DEFINES_SVH
`define EIGHT_QUEENS_NEAREST_PLACEMENT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define EQNP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define EQNP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/eqnp_pkg.sv
// Shared constants and types for the eight queens nearest placement block.
package eqnp_pkg;

    localparam int BOARD_N   = 8;
    localparam int ROW_W     = 4;
    localparam int ROW_BITS  = 3;
    localparam int WORD_W    = BOARD_N * ROW_BITS;
    localparam int DEF_SLOTS = 128;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_ISSUE,
        SC_WAIT,
        SC_HOLD
    } t_scan_state;

    // store write request from the search engine
    typedef struct packed {
        logic              we;
        logic [WORD_W-1:0] data;
    } t_store_wr;

    // valid / last tag that rides along the compare pipeline
    typedef struct packed {
        logic vld;
        logic last;
    } t_pipe;

    // merge result handed back to the scan controller
    typedef struct packed {
        logic             done;
        logic [ROW_W-1:0] min;
    } t_merge_st;

endpackage

// File: src/eight_queens_nearest_placement.sv
// Top level: eight queens nearest valid placement, store plus per-column compare lanes.
// Reset (synchronous, active low) starts a backtracking search, one step per clock, that
//   writes every valid placement (up to SOLUTION_SLOTS) into the store; no request is taken until it ends.
// A request scans the store one entry per cycle through the store read, lane compare and merge
//   stages; the result is registered from the hold state once the merge marks the last entry.
//   One request at a time: the next is taken the cycle after the result is loaded.
module eight_queens_nearest_placement #(
    parameter int SOLUTION_SLOTS = eqnp_pkg::DEF_SLOTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [eqnp_pkg::ROW_W-1:0]   i_row_col1,
    input  logic [eqnp_pkg::ROW_W-1:0]   i_row_col2,
    input  logic [eqnp_pkg::ROW_W-1:0]   i_row_col3,
    input  logic [eqnp_pkg::ROW_W-1:0]   i_row_col4,
    input  logic [eqnp_pkg::ROW_W-1:0]   i_row_col5,
    input  logic [eqnp_pkg::ROW_W-1:0]   i_row_col6,
    input  logic [eqnp_pkg::ROW_W-1:0]   i_row_col7,
    input  logic [eqnp_pkg::ROW_W-1:0]   i_row_col8,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [eqnp_pkg::ROW_W-1:0]   o_min_moves
);
    import eqnp_pkg::*;

    localparam int AW = $clog2(SOLUTION_SLOTS);
    localparam int CW = $clog2(SOLUTION_SLOTS + 1);

    // ---------------- search engine ----------------
    t_store_wr     wr;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] sol_count;
    logic          search_done;

    eqnp_search #(
        .SOLUTION_SLOTS(SOLUTION_SLOTS)
    ) u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_wr      (wr),
        .o_wr_addr (wr_addr),
        .o_count   (sol_count),
        .o_done    (search_done)
    );

    // ---------------- placement store ----------------
    // Only entries below the solution count are ever read, so no clearing is needed.
    logic [WORD_W-1:0] r_mem [SOLUTION_SLOTS];
    logic [WORD_W-1:0] r_q;
    logic [AW-1:0]     r_addr, n_addr;
    logic              rd_en;

    always_ff @(posedge i_clk) begin
        if (wr.we) begin
            r_mem[wr_addr] <= wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_q <= r_mem[r_addr];
        end
    end

    // ---------------- scan control ----------------
    t_scan_state   r_state, n_state;
    logic          in_acc;
    logic          last_addr;
    logic          load_out;
    t_pipe         r_q_pipe, r_d_pipe;
    t_merge_st     mst;
    logic [ROW_W-1:0] r_query [BOARD_N];

    assign in_acc    = i_in_valid && o_in_ready;
    assign last_addr = (CW'(r_addr) + CW'(1)) == sol_count;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SC_IDLE: begin
                if (in_acc) begin
                    // empty store answers the default of eight at once
                    n_state = (sol_count == '0) ? SC_HOLD : SC_ISSUE;
                end
            end
            SC_ISSUE: begin
                if (last_addr) begin
                    n_state = SC_WAIT;
                end
            end
            SC_WAIT: begin
                if (mst.done) begin
                    n_state = SC_HOLD;
                end
            end
            SC_HOLD: begin
                if (!o_out_valid || i_out_ready) begin
                    n_state = SC_IDLE;
                end
            end
            default: n_state = SC_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        o_in_ready = 1'b0;
        rd_en      = 1'b0;
        load_out   = 1'b0;
        n_addr     = r_addr;
        case (r_state)
            SC_IDLE: begin
                o_in_ready = search_done;
                n_addr     = '0;
            end
            SC_ISSUE: begin
                rd_en  = 1'b1;
                n_addr = r_addr + AW'(1);
            end
            SC_WAIT: begin
            end
            SC_HOLD: begin
                load_out = !o_out_valid || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= SC_IDLE;
            r_q_pipe <= '0;
            r_d_pipe <= '0;
        end else begin
            r_state       <= n_state;
            r_q_pipe.vld  <= rd_en;
            r_q_pipe.last <= rd_en && last_addr;
            r_d_pipe      <= r_q_pipe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
    end

    // request rows, held for the whole scan
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_query[0] <= i_row_col1;
            r_query[1] <= i_row_col2;
            r_query[2] <= i_row_col3;
            r_query[3] <= i_row_col4;
            r_query[4] <= i_row_col5;
            r_query[5] <= i_row_col6;
            r_query[6] <= i_row_col7;
            r_query[7] <= i_row_col8;
        end
    end

    // ---------------- column lanes ----------------
    logic [BOARD_N-1:0] diff;

    for (genvar c = 0; c < BOARD_N; c++) begin : g_lane
        eqnp_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (r_q_pipe.vld),
            .i_query  (r_query[c]),
            .i_stored (r_q[c*ROW_BITS +: ROW_BITS]),
            .o_diff   (diff[c])
        );
    end

    // ---------------- merge ----------------
    eqnp_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (in_acc),
        .i_diff  (diff),
        .i_pipe  (r_d_pipe),
        .o_st    (mst)
    );

    // ---------------- result register ----------------
    logic             r_out_valid;
    logic [ROW_W-1:0] r_out_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_min <= mst.min;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_min_moves = r_out_min;

endmodule

// File: src/eqnp_search.sv
// Backtracking enumerator: one search step per clock, writes each placement found while slots remain.
module eqnp_search #(
    parameter int SOLUTION_SLOTS = eqnp_pkg::DEF_SLOTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    output eqnp_pkg::t_store_wr                o_wr,
    output logic [$clog2(SOLUTION_SLOTS)-1:0]  o_wr_addr,
    output logic [$clog2(SOLUTION_SLOTS+1)-1:0] o_count,
    output logic                               o_done
);
    import eqnp_pkg::*;

    localparam int AW = $clog2(SOLUTION_SLOTS);
    localparam int CW = $clog2(SOLUTION_SLOTS + 1);

    logic [ROW_W-1:0] r_row [BOARD_N];
    logic [ROW_W-1:0] n_row [BOARD_N];
    logic [2:0]       r_col, n_col;
    logic             r_done, n_done;
    logic [CW-1:0]    r_count, n_count;

    logic [ROW_W-1:0]  cur;
    logic              safe;
    logic              keep;
    logic [WORD_W-1:0] word;
    logic signed [4:0] dr;
    logic signed [4:0] dc;

    always_comb begin
        cur  = r_row[r_col];
        safe = 1'b1;
        dr   = '0;
        dc   = '0;
        for (int c = 0; c < BOARD_N; c++) begin
            if (3'(c) < r_col) begin
                dr = $signed({1'b0, r_row[c]}) - $signed({1'b0, cur});
                dc = $signed({2'b00, r_col}) - $signed(5'(c));
                if (dr == 5'sd0 || dr == dc || dr == -dc) begin
                    safe = 1'b0;
                end
            end
        end
        for (int c = 0; c < BOARD_N; c++) begin
            word[c*ROW_BITS +: ROW_BITS] = r_row[c][ROW_BITS-1:0];
        end
    end

    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_done  = r_done;
        n_count = r_count;
        keep    = 1'b0;
        if (!r_done) begin
            if (cur[ROW_W-1]) begin
                // rows exhausted in this column: back up
                if (r_col == 3'd0) begin
                    n_done = 1'b1;
                end else begin
                    n_col = r_col - 3'd1;
                    for (int c = 0; c < BOARD_N; c++) begin
                        if (3'(c) == r_col - 3'd1) begin
                            n_row[c] = r_row[c] + 4'd1;
                        end
                    end
                end
            end else if (safe) begin
                if (r_col == 3'(BOARD_N - 1)) begin
                    keep = 1'b1;
                    n_row[BOARD_N-1] = cur + 4'd1;
                    if (r_count < CW'(SOLUTION_SLOTS)) begin
                        n_count = r_count + CW'(1);
                    end
                end else begin
                    n_col = r_col + 3'd1;
                    for (int c = 0; c < BOARD_N; c++) begin
                        if (3'(c) == r_col + 3'd1) begin
                            n_row[c] = '0;
                        end
                    end
                end
            end else begin
                for (int c = 0; c < BOARD_N; c++) begin
                    if (3'(c) == r_col) begin
                        n_row[c] = r_row[c] + 4'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < BOARD_N; c++) begin
                r_row[c] <= '0;
            end
            r_col   <= '0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_done  <= n_done;
            r_count <= n_count;
        end
    end

    assign o_wr.we   = keep && (r_count < CW'(SOLUTION_SLOTS));
    assign o_wr.data = word;
    assign o_wr_addr = r_count[AW-1:0];
    assign o_count   = r_count;
    assign o_done    = r_done;

endmodule

// File: src/eqnp_lane.sv
// One column lane: flags whether the query row differs from the stored row.
module eqnp_lane (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [eqnp_pkg::ROW_W-1:0]         i_query,
    input  logic [eqnp_pkg::ROW_BITS-1:0]      i_stored,
    output logic                               o_diff
);
    import eqnp_pkg::*;

    logic             r_diff;
    logic [ROW_W-1:0] want;

    // stored rows are kept minus one
    assign want = {1'b0, i_stored} + ROW_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= (i_query != want);
        end
    end

    assign o_diff = r_diff;

endmodule

// File: src/eqnp_merge.sv
// Merge stage: counts differing lanes and keeps the running minimum.
module eqnp_merge (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic [eqnp_pkg::BOARD_N-1:0]   i_diff,
    input  eqnp_pkg::t_pipe                i_pipe,
    output eqnp_pkg::t_merge_st            o_st
);
    import eqnp_pkg::*;

    logic [ROW_W-1:0] r_min;
    logic             r_done;
    logic [ROW_W-1:0] cnt;

    always_comb begin
        cnt = '0;
        for (int c = 0; c < BOARD_N; c++) begin
            cnt = cnt + ROW_W'(i_diff[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_min <= ROW_W'(BOARD_N);
        end else if (i_pipe.vld && cnt < r_min) begin
            r_min <= cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_pipe.vld && i_pipe.last;
        end
    end

    assign o_st.done = r_done;
    assign o_st.min  = r_min;

endmodule

// File: src/eqnp_checker.sv
// Port-level checker for the eight queens nearest placement block, with its bind.
`include "eight_queens_nearest_placement_defines.svh"

module eqnp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [eqnp_pkg::ROW_W-1:0]  o_min_moves
);
    import eqnp_pkg::*;

    // result waits unchanged while stalled
    `EQNP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_min_moves))

    // a result never exceeds the board size
    `EQNP_ASSERT_NOW(a_out_range, o_out_valid, o_min_moves <= ROW_W'(BOARD_N))

    // one request at a time: busy right after an accept
    `EQNP_ASSERT_NEXT(a_busy_after_req, i_in_valid && o_in_ready, !o_in_ready)

    // no result can appear in the cycle right after a request is taken
    `EQNP_ASSERT_NEXT(a_no_instant_result, i_in_valid && o_in_ready, !$rose(o_out_valid))

endmodule

bind eight_queens_nearest_placement eqnp_checker u_eqnp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_min_moves (o_min_moves)
);
